// ===== src/otcs_pkg.sv =====
// ----------------------------------------------------------------------------
// otcs_pkg
// Shared types and constants for the outlier-trimmed coverage sum core.
// ----------------------------------------------------------------------------
package otcs_pkg;

    // depth store size and the widths that follow from it
    localparam int C_MAX_POSITIONS = 65536;
    localparam int C_ADDR_W        = $clog2(C_MAX_POSITIONS);
    localparam int C_CNT_W         = C_ADDR_W + 1;

    // field widths
    localparam int C_DEPTH_W = 16;
    localparam int C_FIDX_W  = 4;
    localparam int C_CID_W   = 16;
    localparam int C_SUM_W   = 32;
    localparam int C_SQ_W    = 48;
    localparam int C_DROP_W  = 17;

    // square sum is multiplied in two halves
    localparam int C_SQ_HALF_W = C_SQ_W / 2;
    localparam int C_SPREAD_W  = 64;

    // input beat: one contig position
    typedef struct packed {
        logic [C_DEPTH_W-1:0] depth;
        logic [C_FIDX_W-1:0]  file_index;
        logic [C_CID_W-1:0]   contig_id;
        logic                 last;
    } t_in_beat;

    // output beat: one contig summary
    typedef struct packed {
        logic [C_SUM_W-1:0]  kept_sum;
        logic [C_DROP_W-1:0] dropped_count;
        logic [C_FIDX_W-1:0] out_file_index;
        logic [C_CID_W-1:0]  out_contig_id;
    } t_out_beat;

endpackage

// ===== src/outlier_trimmed_coverage_sum_core.sv =====
// ----------------------------------------------------------------------------
// outlier_trimmed_coverage_sum_core
// Stores the depths of one contig, then sums them, optionally dropping
// depths more than one standard deviation away from the mean.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_data  (t_in_beat)
//  out       output     o_out_valid / i_out_stall o_out_data (t_out_beat)
//  cfg       input      i_cfg_we                  i_cfg_wdata (outlier mode)
//
//  Load pass takes one beat per cycle; the depth memory has one write port.
//  After a last beat, vanilla mode goes straight to the hand-off; outlier
//  mode first runs the spread multiply, then N memory reads and the trim
//  pipeline drain, then hands off the result, N being the stored positions.
//  Reset clears the counters and the mode; the depth memory needs no clearing.
//  Input stalls outside the load pass; a waiting result holds only the
//  next series in its final state, not its load beats.
//
module outlier_trimmed_coverage_sum_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  otcs_pkg::t_in_beat i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output otcs_pkg::t_out_beat o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import otcs_pkg::*;

    // sequencer states
    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_MUL_LO = 3'd1;
    localparam logic [2:0] S_MUL_HI = 3'd2;
    localparam logic [2:0] S_SPREAD = 3'd3;
    localparam logic [2:0] S_TRIM   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic                  r_mode;
    logic                  r_trim;
    logic [C_CNT_W-1:0]    r_count;
    logic [C_SUM_W-1:0]    r_sum;
    logic [C_SQ_W-1:0]     r_sq;
    logic [C_FIDX_W-1:0]   r_res_fidx;
    logic [C_CID_W-1:0]    r_res_cid;

    logic [C_DEPTH_W-1:0]  r_mem [0:C_MAX_POSITIONS-1];
    logic [C_DEPTH_W-1:0]  r_mem_rd;

    logic [C_SQ_HALF_W+C_CNT_W-1:0] r_nq_lo, r_nq_hi;
    logic [C_SPREAD_W-1:0] r_ss;
    logic [C_SPREAD_W-1:0] r_spread;

    logic [C_CNT_W-1:0]    r_rd_addr;
    logic                  r_v0, r_v1, r_v2;
    logic [C_SUM_W-1:0]    r_nx;
    logic [C_DEPTH_W-1:0]  r_x1, r_x2;
    logic [C_SPREAD_W-1:0] r_dsq;
    logic [C_SUM_W-1:0]    r_acc_kept;
    logic [C_CNT_W-1:0]    r_acc_drop;

    logic                  r_out_valid;
    t_out_beat             r_out_data;

    logic                  in_acc;
    logic                  full;
    logic                  store;
    logic                  issue;
    logic                  out_free;
    logic [C_SUM_W-1:0]    diff;

    // handshakes
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign o_in_stall = (r_state != S_LOAD);
    assign full       = (r_count == C_CNT_W'(C_MAX_POSITIONS));
    assign store      = in_acc & ~full;
    assign issue      = (r_state == S_TRIM) && (r_rd_addr != r_count);
    assign out_free   = ~r_out_valid | ~i_out_stall;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_data.last) begin
                    n_state = r_mode ? S_MUL_LO : S_DONE;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SPREAD;
            S_SPREAD: n_state = S_TRIM;
            S_TRIM: begin
                if (!issue && !r_v0 && !r_v1 && !r_v2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // running count, sum and square sum of the series
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else if (store) begin
            r_count <= r_count + C_CNT_W'(1);
            r_sum   <= r_sum + C_SUM_W'(i_in_data.depth);
            r_sq    <= r_sq + C_SQ_W'(32'(i_in_data.depth) * 32'(i_in_data.depth));
        end else if (r_state == S_DONE && out_free) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end
    end

    // closing step: mode and identifiers
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last) begin
            r_trim     <= r_mode;
            r_res_fidx <= i_in_data.file_index;
            r_res_cid  <= i_in_data.contig_id;
        end
    end

    // depth memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_count[C_ADDR_W-1:0]] <= i_in_data.depth;
        end
        r_mem_rd <= r_mem[r_rd_addr[C_ADDR_W-1:0]];
    end

    // spread N*Q - S^2, N*Q in two partial products
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL_LO: begin
                r_nq_lo <= r_count * r_sq[C_SQ_HALF_W-1:0];
            end
            S_MUL_HI: begin
                r_nq_hi <= r_count * r_sq[C_SQ_W-1:C_SQ_HALF_W];
                r_ss    <= r_sum * r_sum;
            end
            S_SPREAD: begin
                r_spread <= C_SPREAD_W'(r_nq_lo)
                          + (C_SPREAD_W'(r_nq_hi) << C_SQ_HALF_W) - r_ss;
            end
            default: begin
            end
        endcase
    end

    // trim pass: read address and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (r_state == S_SPREAD) begin
                r_rd_addr <= '0;
            end else if (issue) begin
                r_rd_addr <= r_rd_addr + C_CNT_W'(1);
            end
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // distance from the mean, scaled by N; below 2^32 for this store size
    assign diff = (r_nx >= r_sum) ? (r_nx - r_sum) : (r_sum - r_nx);

    // trim pipeline datapath
    always_ff @(posedge i_clk) begin
        r_nx  <= C_SUM_W'(r_count) * C_SUM_W'(r_mem_rd);
        r_x1  <= r_mem_rd;
        r_dsq <= diff * diff;
        r_x2  <= r_x1;
    end

    // keep or drop each depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_kept <= '0;
            r_acc_drop <= '0;
        end else if (r_state == S_SPREAD) begin
            r_acc_kept <= '0;
            r_acc_drop <= '0;
        end else if (r_v2) begin
            if (r_dsq <= r_spread) begin
                r_acc_kept <= r_acc_kept + C_SUM_W'(r_x2);
            end else begin
                r_acc_drop <= r_acc_drop + C_CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_data.kept_sum       <= r_trim ? r_acc_kept : r_sum;
            r_out_data.dropped_count  <= r_trim ? C_DROP_W'(r_acc_drop) : '0;
            r_out_data.out_file_index <= r_res_fidx;
            r_out_data.out_contig_id  <= r_res_cid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // stored positions never pass the memory size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_CNT_W'(C_MAX_POSITIONS))
        else $error("position count above store size");

    // read address stays within the series during the trim pass
    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM) |-> (r_rd_addr <= r_count))
        else $error("trim read past series end");

    // a closing beat always leaves the load pass
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last) |=> (r_state != S_LOAD))
        else $error("closing beat did not start finalization");

    // drops of a trimmed series never exceed its positions
    a_drop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIM || (r_state == S_DONE && r_trim))
            |-> (r_acc_drop <= r_count))
        else $error("drop count above position count");
`endif

endmodule

// ===== verif/outlier_trimmed_coverage_sum_core_tb.sv =====
// ----------------------------------------------------------------------------
// outlier_trimmed_coverage_sum_core_tb
// Streams depth series into the core in both trim and plain-sum modes and
// checks each contig summary against an in-bench model of the summation and
// the one-sigma trim. Covers directed corner series, random series with
// random gaps on both sides and a long output hold.
// ----------------------------------------------------------------------------
module outlier_trimmed_coverage_sum_core_tb;

    import otcs_pkg::*;

    localparam int C_HALT_AFTER = 2000000;
    localparam int C_HOLD_CYCLES = 500;
    localparam int C_REPORT_MAX = 10;

    // shapes of depth series used by the random part
    typedef enum int {
        DS_CLUSTER,
        DS_FULL,
        DS_FLAT,
        DS_RAILS,
        DS_TINY
    } depth_shape_e;

    // expected summaries, built from the accepted depth beats
    class coverage_book;
        logic [C_DEPTH_W-1:0] series_depths[$];
        logic [C_SUM_W-1:0]   series_sum = '0;
        logic [C_SQ_W-1:0]    series_sq = '0;
        t_out_beat            awaited[$];
        int                   faults = 0;
        int                   results = 0;
        int                   series_trimmed = 0;
        int                   drops_seen = 0;

        function int pending();
            return awaited.size();
        endfunction

        // add one accepted beat; a last beat closes the series
        function void note_input(t_in_beat b, bit trim_on);
            t_out_beat          want;
            logic [C_SQ_W-1:0]  d;
            logic [63:0]        n;
            logic [63:0]        s;
            logic [63:0]        spread;
            logic [63:0]        nx;
            logic [63:0]        diff;
            logic [C_SUM_W-1:0] kept;
            int unsigned        drops;
            if (series_depths.size() < C_MAX_POSITIONS) begin
                d = b.depth;
                series_depths.push_back(b.depth);
                series_sum = series_sum + b.depth;
                series_sq = series_sq + d * d;
            end
            if (!b.last) return;
            kept = '0;
            drops = 0;
            if (trim_on) begin
                // keep x when (N*x - S)^2 <= N*Q - S^2
                n = series_depths.size();
                s = series_sum;
                spread = n * {16'b0, series_sq} - s * s;
                foreach (series_depths[p]) begin
                    nx = n * series_depths[p];
                    diff = (nx >= s) ? nx - s : s - nx;
                    if (diff * diff <= spread) kept += series_depths[p];
                    else drops++;
                end
                series_trimmed++;
                drops_seen += drops;
            end else begin
                kept = series_sum;
            end
            want.kept_sum = kept;
            want.dropped_count = C_DROP_W'(drops);
            want.out_file_index = b.file_index;
            want.out_contig_id = b.contig_id;
            awaited.push_back(want);
            series_depths.delete();
            series_sum = '0;
            series_sq = '0;
        endfunction

        // compare one accepted summary with the oldest expectation
        function void check_result(t_out_beat got);
            t_out_beat want;
            results++;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= C_REPORT_MAX)
                    $display("unexpected summary beat: %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got.kept_sum !== want.kept_sum
                    || got.dropped_count !== want.dropped_count
                    || got.out_file_index !== want.out_file_index
                    || got.out_contig_id !== want.out_contig_id) begin
                faults++;
                if (faults <= C_REPORT_MAX) begin
                    $display("summary %0d mismatch: sum exp %h got %h, drops exp %0d got %0d",
                             results, want.kept_sum, got.kept_sum,
                             want.dropped_count, got.dropped_count);
                    $display("    file exp %0d got %0d, contig exp %h got %h",
                             want.out_file_index, got.out_file_index,
                             want.out_contig_id, got.out_contig_id);
                end
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_data;
    logic      out_stall = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;

    coverage_book book;
    bit        trim_mode = 1'b0;
    bit        src_gaps = 1'b1;
    bit        sink_gaps = 1'b1;
    int        beats_in = 0;
    int        series_in = 0;

    always #1 clk = ~clk;

    outlier_trimmed_coverage_sum_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // offer one beat, called and returning at a falling edge
    task automatic send_beat(input t_in_beat b);
        while (src_gaps && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge clk); while (in_stall);
        book.note_input(b, trim_mode);
        beats_in++;
        if (b.last) series_in++;
        @(negedge clk);
    endtask

    // write the mode register with the input channel quiet
    task automatic write_mode(input bit m);
        in_valid <= 1'b0;
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        trim_mode = m;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drain all summaries, then let the core go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending() != 0) @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    // directed series from a list of depths
    task automatic send_list(input logic [15:0] depths[$], input logic [3:0] fidx,
                             input logic [15:0] cid);
        t_in_beat b;
        foreach (depths[k]) begin
            b.depth = depths[k];
            b.file_index = fidx;
            b.contig_id = cid;
            b.last = (k == depths.size() - 1);
            send_beat(b);
        end
    endtask

    function automatic logic [15:0] pick_depth(input depth_shape_e shape, input int center);
        int v;
        case (shape)
            DS_CLUSTER: begin
                if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 65535);
                else v = center + $urandom_range(0, 127) - 64;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
            end
            DS_FULL: v = $urandom_range(0, 65535);
            DS_FLAT: v = center;
            DS_RAILS: v = $urandom_range(0, 1) ? 65535 : 0;
            default: v = $urandom_range(0, 15);
        endcase
        return v[15:0];
    endfunction

    // one random series; identifiers mostly steady, sometimes mixed
    task automatic send_series(input int len, input depth_shape_e shape, input bit mix_ids);
        t_in_beat    b;
        int          center;
        logic [3:0]  fidx;
        logic [15:0] cid;
        center = $urandom_range(0, 65535);
        fidx = $urandom_range(0, 15);
        cid = $urandom_range(0, 65535);
        for (int k = 0; k < len; k++) begin
            b.depth = pick_depth(shape, center);
            b.file_index = mix_ids ? 4'($urandom_range(0, 15)) : fidx;
            b.contig_id = mix_ids ? 16'($urandom_range(0, 65535)) : cid;
            b.last = (k == len - 1);
            send_beat(b);
        end
    endtask

    task automatic run_random(input int n_beats);
        int           target;
        int           len;
        int           pick;
        depth_shape_e shape;
        target = beats_in + n_beats;
        while (beats_in < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) len = $urandom_range(1, 24);
            else if (pick < 97) len = $urandom_range(25, 120);
            else len = $urandom_range(121, 400);
            pick = $urandom_range(0, 9);
            if (pick < 4) shape = DS_CLUSTER;
            else if (pick < 6) shape = DS_FULL;
            else if (pick < 7) shape = DS_FLAT;
            else if (pick < 8) shape = DS_RAILS;
            else shape = DS_TINY;
            send_series(len, shape, $urandom_range(0, 9) == 0);
        end
    endtask

    // result side: random stall, one long hold once traffic is flowing
    initial begin : result_sink
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!held_once && book.results >= 30) begin
                held_once = 1'b1;
                hold_left = C_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= sink_gaps && ($urandom_range(0, 99) < 16);
            end
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall) book.check_result(out_data);
        end
    end

    initial begin : watchdog
        #(C_HALT_AFTER);
        $display("timeout with %0d summaries outstanding", book.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] dl[$];
        t_in_beat    b;
        book = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // plain sum from the reset mode: single extremes and mixed identifiers
        dl = '{16'hFFFF};
        send_list(dl, 4'hF, 16'hFFFF);
        dl = '{16'h0000};
        send_list(dl, 4'h0, 16'h0000);
        b = '{depth: 16'd100, file_index: 4'd3, contig_id: 16'h1111, last: 1'b0};
        send_beat(b);
        b = '{depth: 16'd200, file_index: 4'd9, contig_id: 16'h2222, last: 1'b0};
        send_beat(b);
        b = '{depth: 16'hFFFF, file_index: 4'd5, contig_id: 16'hA5A5, last: 1'b1};
        send_beat(b);
        settle();
        write_mode(1'b0);
        dl = '{16'd1, 16'd2, 16'd60000};
        send_list(dl, 4'd7, 16'h5A5A);
        settle();

        // trim mode: lone position, flat series, rails, boundary, clear outlier
        write_mode(1'b1);
        dl = '{16'd4242};
        send_list(dl, 4'd1, 16'h0001);
        dl = '{16'd7, 16'd7, 16'd7};
        send_list(dl, 4'd2, 16'h0002);
        dl = '{16'd0, 16'd0, 16'd0, 16'hFFFF};
        send_list(dl, 4'd4, 16'h8000);
        dl = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
        send_list(dl, 4'd8, 16'h7FFF);
        dl = '{16'd10, 16'd10, 16'd10, 16'd10, 16'd1000};
        send_list(dl, 4'd12, 16'h1234);
        settle();

        // mode flipped between load beats: the closing beat's mode rules
        b = '{depth: 16'd5, file_index: 4'd6, contig_id: 16'h0F0F, last: 1'b0};
        send_beat(b);
        b = '{depth: 16'd5000, file_index: 4'd6, contig_id: 16'h0F0F, last: 1'b0};
        send_beat(b);
        write_mode(1'b0);
        b = '{depth: 16'd6, file_index: 4'd6, contig_id: 16'h0F0F, last: 1'b1};
        send_beat(b);
        settle();
        b = '{depth: 16'd3, file_index: 4'd10, contig_id: 16'hF0F0, last: 1'b0};
        send_beat(b);
        b = '{depth: 16'd3, file_index: 4'd10, contig_id: 16'hF0F0, last: 1'b0};
        send_beat(b);
        write_mode(1'b1);
        b = '{depth: 16'd900, file_index: 4'd10, contig_id: 16'hF0F0, last: 1'b1};
        send_beat(b);
        settle();

        // random series, trim mode, long output hold lands here
        run_random(600);
        settle();

        // plain sum with no idling on either side
        write_mode(1'b0);
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        run_random(450);
        settle();
        src_gaps = 1'b1;
        sink_gaps = 1'b1;

        write_mode(1'b1);
        run_random(650);
        settle();

        repeat (64) @(negedge clk);
        $display("covered %0d depth beats in %0d series, %0d trimmed with %0d drops",
                 beats_in, series_in, book.series_trimmed, book.drops_seen);
        $display("mode flips mid-series and a %0d-cycle output hold",
                 C_HOLD_CYCLES);
        if (book.faults == 0 && book.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d failures, %0d summaries never arrived",
                     book.faults, book.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
